FILE: rtl/accel_repetition_counter_unit_macros.svh
// Assertion macros shared by the repetition counter RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ACCEL_REPETITION_COUNTER_UNIT_MACROS_SVH
`define ACCEL_REPETITION_COUNTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARCU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ARCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/arcu_pkg.sv
// Package for the repetition counter: widths, thresholds, phase types and
// the result record passed from the tracker to the top level. No dependencies.
`default_nettype none

package arcu_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COUNT_W = 8;
	localparam int LED_W = 4;
	localparam int NUM_EXER = 4;
	localparam logic [COUNT_W-1:0] TARGET_RESET = 8'd5;

	// Thresholds on the filtered samples.
	localparam int TH_ARM = -900;
	localparam int TH_HIGH = 900;
	localparam int TH_MID = -600;
	localparam int TH_DEEP = -1200;
	localparam int TH_JACK_LOW = -1600;
	localparam int TH_JACK_HIGH = -200;

	// Counter slots, in the order the counts are updated.
	localparam int IDX_SITUP = 0;
	localparam int IDX_PUSHUP = 1;
	localparam int IDX_SQUAT = 2;
	localparam int IDX_JACK = 3;

	// LED and event bits.
	localparam logic [LED_W-1:0] LED_PUSHUP = 4'b0001;
	localparam logic [LED_W-1:0] LED_SQUAT = 4'b0010;
	localparam logic [LED_W-1:0] LED_JACK = 4'b0100;
	localparam logic [LED_W-1:0] LED_SITUP = 4'b1000;
	localparam logic [LED_W-1:0] LED_ALL = 4'b1111;
	localparam logic [LED_W-1:0] LED_MASK [NUM_EXER] = '{LED_SITUP, LED_PUSHUP,
		LED_SQUAT, LED_JACK};

	typedef enum logic {
		SU_IDLE,
		SU_ARMED
	} su_phase_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_FIRST = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	typedef struct packed {
		logic [COUNT_W-1:0] situp_count;
		logic [COUNT_W-1:0] pushup_count;
		logic [COUNT_W-1:0] squat_count;
		logic [COUNT_W-1:0] jack_count;
		logic [LED_W-1:0] rep_events;
		logic set_done;
		logic [LED_W-1:0] led_levels;
	} rep_result_t;

	// Next phase of a three-threshold machine.
	function automatic phase_t ph_next(phase_t ph, logic start, logic mid, logic fin);
		phase_t nx;
		nx = ph;
		unique case (ph)
			PH_IDLE: if (start) nx = PH_FIRST;
			PH_FIRST: if (mid) nx = PH_SECOND;
			PH_SECOND: if (fin) nx = PH_IDLE;
			default: nx = ph;
		endcase
		return nx;
	endfunction

	// A repetition is counted when the last threshold is crossed.
	function automatic logic ph_hit(phase_t ph, logic fin);
		return (ph == PH_SECOND) && fin;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/arcu_channels.sv
// Handshake channels of the repetition counter: sample input and result output.
// Depends on arcu_pkg.
`default_nettype none

interface arcu_sample_if #(
	parameter int SAMPLE_WIDTH = arcu_pkg::SAMPLE_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] raw_x;
	logic signed [SAMPLE_WIDTH-1:0] raw_z;

	modport source(output valid, raw_x, raw_z, input ready);
	modport sink(input valid, raw_x, raw_z, output ready);
endinterface

interface arcu_result_if;
	import arcu_pkg::*;

	logic valid;
	logic ready;
	logic [COUNT_W-1:0] situp_count;
	logic [COUNT_W-1:0] pushup_count;
	logic [COUNT_W-1:0] squat_count;
	logic [COUNT_W-1:0] jack_count;
	logic [LED_W-1:0] rep_events;
	logic set_done;
	logic [LED_W-1:0] led_levels;

	modport source(output valid, situp_count, pushup_count, squat_count, jack_count,
		rep_events, set_done, led_levels, input ready);
	modport sink(input valid, situp_count, pushup_count, squat_count, jack_count,
		rep_events, set_done, led_levels, output ready);
endinterface

`default_nettype wire

FILE: rtl/arcu_lowpass.sv
// One-axis low-pass filter, new = (2*raw + 3*prev) / 5 truncated toward zero.
// The filter state register doubles as the stage-two sample. Depends on arcu_pkg.
`default_nettype none

module arcu_lowpass #(
	parameter int SAMPLE_WIDTH = arcu_pkg::SAMPLE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire logic signed [SAMPLE_WIDTH-1:0] raw,
	output logic signed [SAMPLE_WIDTH-1:0] filt_s2
);
	import arcu_pkg::*;

	// Sum needs three extra bits, its magnitude two.
	localparam int SUM_W = SAMPLE_WIDTH + 3;
	localparam int MAG_W = SAMPLE_WIDTH + 2;
	// Reciprocal of five, exact for every magnitude below 2**MAG_W.
	localparam int RSHIFT = MAG_W + 3;
	localparam int RECIP_W = RSHIFT - 2;
	localparam int PROD_W = MAG_W + RECIP_W;
	localparam logic [63:0] RECIP64 = ((64'd1 << RSHIFT) + 64'd4) / 64'd5;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

	logic signed [SUM_W-1:0] raw_e;
	logic signed [SUM_W-1:0] prev_e;
	logic signed [SUM_W-1:0] sum;
	logic sum_neg;
	logic [MAG_W-1:0] mag;
	logic [PROD_W-1:0] prod;
	logic [SAMPLE_WIDTH-1:0] quot;
	logic signed [SAMPLE_WIDTH-1:0] filt_nx;

	// Weighted sum, then divide the magnitude by five and restore the sign.
	always_comb begin
		raw_e = SUM_W'(raw);
		prev_e = SUM_W'(filt_s2);
		sum = (raw_e <<< 1) + (prev_e <<< 1) + prev_e;
		sum_neg = sum[SUM_W-1];
		mag = sum_neg ? MAG_W'(-sum) : MAG_W'(sum);
		prod = PROD_W'(mag) * PROD_W'(RECIP);
		quot = SAMPLE_WIDTH'(prod >> RSHIFT);
		filt_nx = sum_neg ? signed'(-quot) : signed'(quot);
	end

	// Filter state, updated once for each sample that passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_s2 <= '0;
		end else if (load) begin
			filt_s2 <= filt_nx;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/arcu_tracker.sv
// Exercise tracker: four threshold state machines, repetition counters, LEDs
// and the registered result. Depends on arcu_pkg and the assertion macros.
`default_nettype none
`include "accel_repetition_counter_unit_macros.svh"

module arcu_tracker #(
	parameter int SAMPLE_WIDTH = arcu_pkg::SAMPLE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire logic signed [SAMPLE_WIDTH-1:0] filt_x,
	input wire logic signed [SAMPLE_WIDTH-1:0] filt_z,
	input wire logic [arcu_pkg::COUNT_W-1:0] rep_target,
	output arcu_pkg::rep_result_t res_s3
);
	import arcu_pkg::*;

	localparam logic signed [SAMPLE_WIDTH-1:0] C_ARM = SAMPLE_WIDTH'(TH_ARM);
	localparam logic signed [SAMPLE_WIDTH-1:0] C_HIGH = SAMPLE_WIDTH'(TH_HIGH);
	localparam logic signed [SAMPLE_WIDTH-1:0] C_MID = SAMPLE_WIDTH'(TH_MID);
	localparam logic signed [SAMPLE_WIDTH-1:0] C_DEEP = SAMPLE_WIDTH'(TH_DEEP);
	localparam logic signed [SAMPLE_WIDTH-1:0] C_JLOW = SAMPLE_WIDTH'(TH_JACK_LOW);
	localparam logic signed [SAMPLE_WIDTH-1:0] C_JHIGH = SAMPLE_WIDTH'(TH_JACK_HIGH);

	su_phase_t su_q, su_nx;
	phase_t pu_q, pu_nx;
	phase_t sq_q, sq_nx;
	phase_t jk_q, jk_nx;
	logic [COUNT_W-1:0] cnt_q [NUM_EXER];
	logic [COUNT_W-1:0] cnt_nx [NUM_EXER];
	logic [LED_W-1:0] led_q, led_nx;
	logic [NUM_EXER-1:0] hit;
	logic [LED_W-1:0] ev;
	logic done;
	logic [COUNT_W-1:0] cnt_tmp;
	logic su_mid;

	// Threshold machines for all four exercises.
	always_comb begin
		// Sit-up: arming and counting are separate tests in one sample.
		su_mid = (su_q == SU_ARMED) || (filt_x <= C_ARM);
		hit[IDX_SITUP] = su_mid && (filt_z >= C_HIGH);
		su_nx = (su_mid && !hit[IDX_SITUP]) ? SU_ARMED : SU_IDLE;

		pu_nx = ph_next(pu_q, filt_z <= C_ARM, filt_z >= C_MID, filt_z <= C_DEEP);
		hit[IDX_PUSHUP] = ph_hit(pu_q, filt_z <= C_DEEP);

		// A squat may only start while no jumping jack has been counted.
		sq_nx = ph_next(sq_q, (cnt_q[IDX_JACK] == '0) && (filt_x <= C_ARM),
			filt_x >= C_MID, filt_x <= C_DEEP);
		hit[IDX_SQUAT] = ph_hit(sq_q, filt_x <= C_DEEP);

		jk_nx = ph_next(jk_q, filt_x <= C_JLOW, filt_x >= C_JHIGH, filt_x <= C_ARM);
		hit[IDX_JACK] = ph_hit(jk_q, filt_x <= C_ARM);
	end

	// Counters in update order; each LED change and target match applies in turn.
	always_comb begin
		led_nx = led_q;
		ev = '0;
		done = 1'b0;
		cnt_tmp = '0;
		for (int i = 0; i < NUM_EXER; i++) begin
			cnt_tmp = cnt_q[i] + COUNT_W'(hit[i]);
			if (hit[i]) begin
				led_nx = led_nx ^ LED_MASK[i];
				ev = ev | LED_MASK[i];
			end
			if (cnt_tmp == rep_target) begin
				led_nx = LED_ALL;
				cnt_tmp = '0;
				done = 1'b1;
			end
			cnt_nx[i] = cnt_tmp;
		end
		// Squat LED stays dark while jumping jacks are in progress.
		if (cnt_nx[IDX_JACK] != '0) begin
			led_nx = led_nx & ~LED_SQUAT;
		end
	end

	// Machine state, counters and LEDs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			su_q <= SU_IDLE;
			pu_q <= PH_IDLE;
			sq_q <= PH_IDLE;
			jk_q <= PH_IDLE;
			led_q <= '0;
			for (int i = 0; i < NUM_EXER; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (load) begin
			su_q <= su_nx;
			pu_q <= pu_nx;
			sq_q <= sq_nx;
			jk_q <= jk_nx;
			led_q <= led_nx;
			for (int i = 0; i < NUM_EXER; i++) begin
				cnt_q[i] <= cnt_nx[i];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (load) begin
			res_s3.situp_count <= cnt_nx[IDX_SITUP];
			res_s3.pushup_count <= cnt_nx[IDX_PUSHUP];
			res_s3.squat_count <= cnt_nx[IDX_SQUAT];
			res_s3.jack_count <= cnt_nx[IDX_JACK];
			res_s3.rep_events <= ev;
			res_s3.set_done <= done;
			res_s3.led_levels <= led_nx;
		end
	end

	`ARCU_ASSERT_NEXT(a_cnt_below_target, load && (rep_target != '0),
		res_s3.situp_count != $past(rep_target), "sit-up count left equal to target")
	`ARCU_ASSERT_NEXT(a_squat_led_masked, load,
		(res_s3.jack_count == '0) || ((res_s3.led_levels & LED_SQUAT) == '0),
		"squat LED lit during jacks")
	`ARCU_ASSERT_NEXT(a_zero_target_done, load && (rep_target == '0),
		res_s3.set_done, "zero target did not flag set done")

endmodule

`default_nettype wire

FILE: rtl/accel_repetition_counter_unit.sv
// Accelerometer repetition counter, top level: input register, X/Z filters,
// exercise tracker and result register. Depends on arcu_pkg and the channels.
// A sample passes the input register, filter state and result register in turn.
// Throughput: one sample per cycle; each stage moves whenever the next has room.
// Reset: asynchronous; filters, phases, counters and LEDs clear, target is 5.
`default_nettype none
`include "accel_repetition_counter_unit_macros.svh"

module accel_repetition_counter_unit #(
	parameter int SAMPLE_WIDTH = arcu_pkg::SAMPLE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	arcu_sample_if.sink sample_ch,
	arcu_result_if.source result_ch,
	input wire logic cfg_we,
	input wire logic [arcu_pkg::COUNT_W-1:0] cfg_wdata
);
	import arcu_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;
	logic signed [SAMPLE_WIDTH-1:0] raw_x_s1, raw_z_s1;
	logic signed [SAMPLE_WIDTH-1:0] filt_x_s2, filt_z_s2;
	logic [COUNT_W-1:0] rep_target_q;
	rep_result_t res_s3;

	// A stage may take new data when empty or when its contents move on.
	assign adv_s3 = !valid_s3 || result_ch.ready;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign sample_ch.ready = adv_s1;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= sample_ch.valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	// Input register, loaded on each sample transfer.
	always_ff @(posedge clk) begin
		if (adv_s1 && sample_ch.valid) begin
			raw_x_s1 <= sample_ch.raw_x;
			raw_z_s1 <= sample_ch.raw_z;
		end
	end

	// Repetition target register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_target_q <= TARGET_RESET;
		end else if (cfg_we) begin
			rep_target_q <= cfg_wdata;
		end
	end

	arcu_lowpass #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_filt_x (
		.clk(clk),
		.arst_n(arst_n),
		.load(valid_s1 && adv_s2),
		.raw(raw_x_s1),
		.filt_s2(filt_x_s2)
	);

	arcu_lowpass #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_filt_z (
		.clk(clk),
		.arst_n(arst_n),
		.load(valid_s1 && adv_s2),
		.raw(raw_z_s1),
		.filt_s2(filt_z_s2)
	);

	arcu_tracker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.load(valid_s2 && adv_s3),
		.filt_x(filt_x_s2),
		.filt_z(filt_z_s2),
		.rep_target(rep_target_q),
		.res_s3(res_s3)
	);

	// Result channel.
	assign result_ch.valid = valid_s3;
	assign result_ch.situp_count = res_s3.situp_count;
	assign result_ch.pushup_count = res_s3.pushup_count;
	assign result_ch.squat_count = res_s3.squat_count;
	assign result_ch.jack_count = res_s3.jack_count;
	assign result_ch.rep_events = res_s3.rep_events;
	assign result_ch.set_done = res_s3.set_done;
	assign result_ch.led_levels = res_s3.led_levels;

	`ARCU_ASSERT_SAME(a_result_from_s2, $rose(valid_s3), $past(valid_s2),
		"result appeared without a filtered sample")
	`ARCU_ASSERT_SAME(a_ready_when_empty, !valid_s1, sample_ch.ready,
		"input not ready with empty input register")
	`ARCU_ASSERT_NEXT(a_s2_held, valid_s2 && !adv_s2, valid_s2,
		"stalled filtered sample was lost")

endmodule

`default_nettype wire
